>>> hdl/pidc_pkg.sv
// Shared types, codes and clamp helper for the PID controller step block.
package pidc_pkg;

  localparam int FracBits = 16;
  localparam int RegIdxW  = 3;

  localparam logic [15:0] RESET_HIGH_LIMIT = 16'sd100;
  localparam logic [15:0] RESET_PERIOD_MS  = 16'd100;

  // Item kinds
  localparam logic [1:0] KIND_COMPUTE = 2'd0;
  localparam logic [1:0] KIND_AUTO    = 2'd1;
  localparam logic [1:0] KIND_MANUAL  = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [RegIdxW-1:0] REG_KP     = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KI     = 3'd1;
  localparam logic [RegIdxW-1:0] REG_KD     = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LOW    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HIGH   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_PERIOD = 3'd5;

  typedef struct packed {
    logic signed [23:0] kp;
    logic signed [23:0] ki;
    logic signed [23:0] kd;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic        [15:0] period;
  } cfg_t;

  // Clamp a Q.16 value to the integer limits; high limit is tested first.
  function automatic logic signed [31:0] clamp_q16(
    input logic signed [43:0] v,
    input logic signed [15:0] lo,
    input logic signed [15:0] hi
  );
    logic signed [43:0] hi_q;
    logic signed [43:0] lo_q;
    hi_q = {{12{hi[15]}}, hi, 16'h0000};
    lo_q = {{12{lo[15]}}, lo, 16'h0000};
    if (v > hi_q) begin
      clamp_q16 = {hi, 16'h0000};
    end else if (v < lo_q) begin
      clamp_q16 = {lo, 16'h0000};
    end else begin
      clamp_q16 = v[31:0];
    end
  endfunction

endpackage

>>> hdl/pidc_regs.sv
// APB-style configuration registers for the PID controller step block.
module pidc_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pidc_pkg::cfg_t     cfg
);
  import pidc_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [RegIdxW-1:0]   idx;
  logic                 wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_KP:     cfg_nxt.kp     = pwdata[23:0];
        REG_KI:     cfg_nxt.ki     = pwdata[23:0];
        REG_KD:     cfg_nxt.kd     = pwdata[23:0];
        REG_LOW:    cfg_nxt.low    = pwdata[15:0];
        REG_HIGH:   cfg_nxt.high   = pwdata[15:0];
        REG_PERIOD: cfg_nxt.period = pwdata[15:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_KP:     prdata = {{8{cfg_r.kp[23]}}, cfg_r.kp};
      REG_KI:     prdata = {{8{cfg_r.ki[23]}}, cfg_r.ki};
      REG_KD:     prdata = {{8{cfg_r.kd[23]}}, cfg_r.kd};
      REG_LOW:    prdata = {{16{cfg_r.low[15]}}, cfg_r.low};
      REG_HIGH:   prdata = {{16{cfg_r.high[15]}}, cfg_r.high};
      REG_PERIOD: prdata = {16'h0000, cfg_r.period};
      default:    prdata = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp     <= '0;
      cfg_r.ki     <= '0;
      cfg_r.kd     <= '0;
      cfg_r.low    <= '0;
      cfg_r.high   <= RESET_HIGH_LIMIT;
      cfg_r.period <= RESET_PERIOD_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/pidc_core.sv
// Controller state and single-pass PID datapath for one registered item.
module pidc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [1:0]          kind,
  input  logic signed [15:0]  measurement,
  input  logic signed [15:0]  setpoint,
  input  logic [31:0]         now_ms,
  input  logic signed [15:0]  manual_output,
  input  pidc_pkg::cfg_t      cfg,
  output logic signed [31:0]  drive,
  output logic                updated,
  output logic                automatic_res
);
  import pidc_pkg::*;

  logic signed [31:0] integral_r, integral_nxt;
  logic signed [15:0] prev_meas_r, prev_meas_nxt;
  logic        [31:0] prev_time_r, prev_time_nxt;
  logic signed [31:0] held_r, held_nxt;
  logic               auto_r, auto_nxt;

  logic signed [16:0] err;
  logic signed [16:0] dmeas;
  logic signed [40:0] kp_term;
  logic signed [40:0] ki_term;
  logic signed [40:0] kd_term;
  logic signed [31:0] int_new;
  logic signed [43:0] pid_sum;
  logic signed [31:0] seed;
  logic        [31:0] elapsed;
  logic               do_compute;
  logic               want_auto;

  assign err     = {setpoint[15], setpoint} - {measurement[15], measurement};
  assign dmeas   = {measurement[15], measurement} - {prev_meas_r[15], prev_meas_r};
  assign kp_term = cfg.kp * err;
  assign ki_term = cfg.ki * err;
  assign kd_term = cfg.kd * dmeas;
  assign int_new = clamp_q16(44'(ki_term) + 44'(integral_r), cfg.low, cfg.high);
  assign pid_sum = 44'(kp_term) + 44'(int_new) - 44'(kd_term);
  assign seed    = clamp_q16({{12{manual_output[15]}}, manual_output, 16'h0000},
                             cfg.low, cfg.high);
  assign elapsed = now_ms - prev_time_r;
  assign do_compute = (kind == KIND_COMPUTE) && auto_r && (elapsed >= {16'h0000, cfg.period});
  assign want_auto  = (kind == KIND_AUTO);

  always_comb begin
    integral_nxt  = integral_r;
    prev_meas_nxt = prev_meas_r;
    prev_time_nxt = prev_time_r;
    held_nxt      = held_r;
    auto_nxt      = auto_r;
    if (do_compute) begin
      integral_nxt  = int_new;
      held_nxt      = clamp_q16(pid_sum, cfg.low, cfg.high);
      prev_meas_nxt = measurement;
      prev_time_nxt = now_ms;
    end else if (kind == KIND_AUTO || kind == KIND_MANUAL) begin
      // seed only on a real mode switch
      if (want_auto != auto_r) begin
        integral_nxt  = seed;
        prev_meas_nxt = measurement;
      end
      auto_nxt = want_auto;
    end
  end

  assign drive         = held_nxt;
  assign updated       = do_compute;
  assign automatic_res = auto_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r  <= '0;
      prev_meas_r <= '0;
      prev_time_r <= '0;
      held_r      <= '0;
      auto_r      <= 1'b0;
    end else if (go) begin
      integral_r  <= integral_nxt;
      prev_meas_r <= prev_meas_nxt;
      prev_time_r <= prev_time_nxt;
      held_r      <= held_nxt;
      auto_r      <= auto_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(integral_r) && $stable(held_r) && $stable(auto_r))
    else $error("controller state moved without an item");
  a_update_needs_auto: assert property (@(posedge clk) disable iff (!rst_n)
    go && updated |=> auto_r && (prev_time_r == $past(now_ms)))
    else $error("computation outside automatic mode or time not recorded");
  a_mode_item_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    go && kind != KIND_COMPUTE |=> $stable(held_r))
    else $error("mode item changed the held drive");
`endif

endmodule

>>> hdl/pid_controller_step.sv
// Top level of the sampled PID controller step block.
//
// Usage: each input transaction (in_valid high, in_stall low at a clock edge)
// carries a kind, a measurement, a setpoint, a millisecond time and a manual
// drive. Every transaction yields exactly one result transaction on the out_
// channel: the held drive (Q16.16), whether this item ran a computation, and
// the automatic-mode flag after the item.
// Throughput: one item per cycle while the receiver does not stall; the state
// update (integral, held drive, mode) happens in the single pass from the
// input register to the result register. A receiver stall holds the result
// register; the input register still takes one more item, after which
// in_stall rises until the result moves on. Reset (rst_n low, synchronous)
// empties both registers, puts the controller in manual mode with zero
// integral and drive, and loads register defaults (high limit 100, sample
// period 100 ms). Registers are written over the APB port at byte address
// 4*index; the user must write them only while no transaction is in flight,
// which the block itself does not enforce.
module pid_controller_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_measurement,
  input  logic signed [15:0] in_setpoint,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_manual_output,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive,
  output logic               out_updated,
  output logic               out_automatic_res
);
  import pidc_pkg::*;

  cfg_t               cfg;
  logic               s1_valid_r;
  logic [1:0]         s1_kind_r;
  logic signed [15:0] s1_meas_r;
  logic signed [15:0] s1_sp_r;
  logic [31:0]        s1_now_r;
  logic signed [15:0] s1_man_r;
  logic               out_valid_r;
  logic signed [31:0] out_drive_r;
  logic               out_updated_r;
  logic               out_auto_r;
  logic               out_ready;
  logic               advance;
  logic               in_take;
  logic signed [31:0] core_drive;
  logic               core_updated;
  logic               core_auto;

  pidc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  pidc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (advance),
    .kind          (s1_kind_r),
    .measurement   (s1_meas_r),
    .setpoint      (s1_sp_r),
    .now_ms        (s1_now_r),
    .manual_output (s1_man_r),
    .cfg           (cfg),
    .drive         (core_drive),
    .updated       (core_updated),
    .automatic_res (core_auto)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind_r <= in_kind;
      s1_meas_r <= in_measurement;
      s1_sp_r   <= in_setpoint;
      s1_now_r  <= in_now_ms;
      s1_man_r  <= in_manual_output;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_r   <= core_drive;
      out_updated_r <= core_updated;
      out_auto_r    <= core_auto;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_drive         = out_drive_r;
  assign out_updated       = out_updated_r;
  assign out_automatic_res = out_auto_r;

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_drive_r))
    else $error("stalled result overwritten or dropped");
  a_update_is_auto: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_updated_r |-> out_auto_r)
    else $error("computation reported in manual mode");
`endif

endmodule

>>> test/pid_step_monitor.sv
// Watches the PID step block's ports, predicts every result and compares it.
module pid_step_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [15:0] in_measurement,
  input  logic signed [15:0] in_setpoint,
  input  logic [31:0]        in_now_ms,
  input  logic signed [15:0] in_manual_output,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_drive,
  input  logic               out_updated,
  input  logic               out_automatic_res,
  output int                 fail_count,
  output int                 drives_pending,
  output int                 drives_checked,
  output int                 updates_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  localparam longint OneQ16 = 64'sd1 <<< FracBits;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               updated;
    logic               automatic_res;
  } drive_result_t;

  cfg_t              gains;
  longint            integ_q16;
  longint            held_q16;
  logic signed [15:0] last_meas;
  logic [31:0]       last_time;
  logic              auto_mode;
  drive_result_t     expected_drives[$];
  int                errs;
  int                checked;
  int                updates;

  function automatic longint clamp_to_limits(longint v);
    longint hi;
    longint lo;
    hi = longint'($signed(gains.high)) * OneQ16;
    lo = longint'($signed(gains.low)) * OneQ16;
    // high limit is tested first, so it wins for values above it when the limits cross
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic drive_result_t predict_drive(
    input logic [1:0]         kind,
    input logic signed [15:0] meas,
    input logic signed [15:0] sp,
    input logic [31:0]        now,
    input logic signed [15:0] manual
  );
    drive_result_t r;
    longint        err;
    longint        dmeas;
    logic [31:0]   elapsed;
    logic          want_auto;
    r.updated = 1'b0;
    elapsed = now - last_time;
    case (kind)
      KIND_COMPUTE: begin
        if (auto_mode && elapsed >= {16'h0000, gains.period}) begin
          err = longint'(sp) - longint'(meas);
          dmeas = longint'(meas) - longint'(last_meas);
          integ_q16 = clamp_to_limits(integ_q16 + longint'($signed(gains.ki)) * err);
          held_q16 = clamp_to_limits(longint'($signed(gains.kp)) * err + integ_q16
                                     - longint'($signed(gains.kd)) * dmeas);
          last_meas = meas;
          last_time = now;
          r.updated = 1'b1;
        end
      end
      KIND_AUTO, KIND_MANUAL: begin
        want_auto = (kind == KIND_AUTO);
        if (want_auto != auto_mode) begin
          integ_q16 = clamp_to_limits(longint'(manual) * OneQ16);
          last_meas = meas;
        end
        auto_mode = want_auto;
      end
      default: begin
      end
    endcase
    r.drive = held_q16[31:0];
    r.automatic_res = auto_mode;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t exp_r;
    if (!rst_n) begin
      gains = '0;
      gains.high = RESET_HIGH_LIMIT;
      gains.period = RESET_PERIOD_MS;
      integ_q16 = 0;
      held_q16 = 0;
      last_meas = '0;
      last_time = '0;
      auto_mode = 1'b0;
      expected_drives.delete();
      errs = 0;
      checked = 0;
      updates = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_KP:     gains.kp = pwdata[23:0];
          REG_KI:     gains.ki = pwdata[23:0];
          REG_KD:     gains.kd = pwdata[23:0];
          REG_LOW:    gains.low = pwdata[15:0];
          REG_HIGH:   gains.high = pwdata[15:0];
          REG_PERIOD: gains.period = pwdata[15:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_drives.push_back(predict_drive(in_kind, in_measurement, in_setpoint,
                                                in_now_ms, in_manual_output));
      end
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          $display("%0t: result transaction with nothing expected: drive %0d", $time,
                   out_drive);
          errs++;
        end else begin
          exp_r = expected_drives.pop_front();
          checked++;
          if (out_updated) updates++;
          if (out_drive !== exp_r.drive) begin
            $display("%0t: drive mismatch: expected %0d, actual %0d", $time,
                     exp_r.drive, out_drive);
            errs++;
          end
          if (out_updated !== exp_r.updated) begin
            $display("%0t: updated mismatch: expected %0b, actual %0b", $time,
                     exp_r.updated, out_updated);
            errs++;
          end
          if (out_automatic_res !== exp_r.automatic_res) begin
            $display("%0t: automatic_res mismatch: expected %0b, actual %0b", $time,
                     exp_r.automatic_res, out_automatic_res);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    drives_pending <= expected_drives.size();
    drives_checked <= checked;
    updates_seen <= updates;
  end

endmodule

>>> test/tb_pid_controller_step.sv
// Stimulus and verdict for the PID controller step block.
module tb_pid_controller_step;
  timeunit 1ns;
  timeprecision 1ps;
  import pidc_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int IdleLimit   = 3000;
  localparam int HoldCycles  = 200;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 245;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_kind;
  logic signed [15:0] in_measurement;
  logic signed [15:0] in_setpoint;
  logic [31:0]        in_now_ms;
  logic signed [15:0] in_manual_output;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_drive;
  logic               out_updated;
  logic               out_automatic_res;

  int                 fail_count;
  int                 drives_pending;
  int                 drives_checked;
  int                 updates_seen;

  int                 burst_left;
  int                 idle_cycles;
  int                 settings_loaded;
  logic [15:0]        period_now;
  logic [31:0]        clock_ms;
  logic signed [15:0] target;

  pid_controller_step dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_measurement(in_measurement), .in_setpoint(in_setpoint),
    .in_now_ms(in_now_ms), .in_manual_output(in_manual_output),
    .out_valid(out_valid), .out_stall(out_stall), .out_drive(out_drive),
    .out_updated(out_updated), .out_automatic_res(out_automatic_res)
  );

  pid_step_monitor monitor (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_measurement(in_measurement), .in_setpoint(in_setpoint),
    .in_now_ms(in_now_ms), .in_manual_output(in_manual_output),
    .out_valid(out_valid), .out_stall(out_stall), .out_drive(out_drive),
    .out_updated(out_updated), .out_automatic_res(out_automatic_res),
    .fail_count(fail_count), .drives_pending(drives_pending),
    .drives_checked(drives_checked), .updates_seen(updates_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall segments of random density, now and then a long hold-off.
  initial begin
    int seg;
    int len;
    int pct;
    out_stall = 1'b0;
    seg = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      seg++;
      if (seg % 25 == 12) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        len = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 20;
          2: pct = 50;
          default: pct = 85;
        endcase
        repeat (len) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_setting(input cfg_t s);
    apb_write({REG_KP, 2'b00}, {{8{s.kp[23]}}, s.kp});
    apb_write({REG_KI, 2'b00}, {{8{s.ki[23]}}, s.ki});
    apb_write({REG_KD, 2'b00}, {{8{s.kd[23]}}, s.kd});
    apb_write({REG_LOW, 2'b00}, {{16{s.low[15]}}, s.low});
    apb_write({REG_HIGH, 2'b00}, {{16{s.high[15]}}, s.high});
    apb_write({REG_PERIOD, 2'b00}, {16'h0000, s.period});
    period_now = s.period;
    settings_loaded++;
  endtask

  function automatic cfg_t pick_setting(input int idx);
    cfg_t s;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] t;
    s.kp = 24'($urandom());
    s.ki = 24'($urandom());
    s.kd = 24'($urandom());
    a = 16'($urandom());
    b = 16'($urandom());
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    s.low = a;
    s.high = b;
    s.period = 16'($urandom_range(0, 40));
    case (idx)
      0: begin
        s.kp = 24'h7FFFFF;
        s.ki = 24'h800000;
        s.kd = 24'h7FFFFF;
        s.low = 16'sh8000;
        s.high = 16'sh7FFF;
        s.period = 16'd1;
      end
      1: begin
        s.kp = 24'h800000;
        s.ki = 24'h7FFFFF;
        s.kd = 24'h800000;
        s.low = 16'sh8000;
        s.high = 16'sh7FFF;
        s.period = 16'd0;
      end
      2: begin
        s.kp = '0;
        s.ki = '0;
        s.kd = '0;
        s.low = 16'sd0;
        s.high = 16'sd100;
        s.period = 16'd100;
      end
      3: begin
        // crossed limits
        s.low = 16'($urandom_range(1, 1000));
        s.high = -$signed(16'($urandom_range(0, 1000)));
      end
      4: s.period = 16'hFFFF;
      default: begin
      end
    endcase
    return s;
  endfunction

  task automatic send_item(
    input logic [1:0]         kind,
    input logic signed [15:0] meas,
    input logic signed [15:0] sp,
    input logic [31:0]        now,
    input logic signed [15:0] manual
  );
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_kind <= kind;
    in_measurement <= meas;
    in_setpoint <= sp;
    in_now_ms <= now;
    in_manual_output <= manual;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    int pick;
    logic [1:0] kind;
    logic signed [15:0] sp;
    logic signed [15:0] meas;
    pick = $urandom_range(0, 99);
    if (pick < 78) kind = KIND_COMPUTE;
    else if (pick < 87) kind = KIND_AUTO;
    else if (pick < 95) kind = KIND_MANUAL;
    else kind = KIND_UNUSED;
    if ($urandom_range(0, 9) == 0) clock_ms = $urandom();
    else clock_ms = clock_ms + $urandom_range(0, 2 * int'(period_now) + 3);
    sp = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : target;
    if ($urandom_range(0, 3) == 0) meas = 16'($urandom());
    else meas = sp + 16'($urandom_range(0, 400)) - 16'sd200;
    send_item(kind, meas, sp, clock_ms, 16'($urandom()));
  endtask

  // Drop valid and hold until every result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    cfg_t s;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_kind = KIND_COMPUTE;
    in_measurement = '0;
    in_setpoint = '0;
    in_now_ms = '0;
    in_manual_output = '0;
    burst_left = 0;
    settings_loaded = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    s.kp = 24'h018000;
    s.ki = 24'h004000;
    s.kd = 24'h008000;
    s.low = -16'sd100;
    s.high = 16'sd100;
    s.period = 16'd10;
    load_setting(s);
    send_item(KIND_COMPUTE, 16'sd10, 16'sd20, 32'd1000, 16'sd0);
    send_item(KIND_MANUAL, 16'sd5, 16'sd0, 32'd1000, 16'sd30);
    send_item(KIND_AUTO, 16'sd10, 16'sd0, 32'd1000, 16'sd50);
    send_item(KIND_AUTO, 16'sd99, 16'sd0, 32'd1000, -16'sd7);
    send_item(KIND_COMPUTE, 16'sd10, 16'sd20, 32'd1005, 16'sd0);
    send_item(KIND_COMPUTE, 16'sd11, 16'sd20, 32'd1014, 16'sd0);
    send_item(KIND_COMPUTE, 16'sd12, 16'sd20, 32'd1015, 16'sd0);
    send_item(KIND_COMPUTE, 16'sh8000, 16'sh7FFF, 32'd1100, 16'sd0);
    send_item(KIND_COMPUTE, 16'sh7FFF, 16'sh8000, 32'd1200, 16'sh7FFF);
    send_item(KIND_UNUSED, 16'sd0, 16'sd0, 32'd1300, 16'sd1);
    send_item(KIND_MANUAL, 16'sd3, 16'sd0, 32'd1300, 16'sh8000);
    send_item(KIND_COMPUTE, 16'sd0, 16'sd50, 32'd2000, 16'sd0);
    send_item(KIND_AUTO, 16'sd0, 16'sd0, 32'd2000, 16'sh7FFF);
    send_item(KIND_COMPUTE, 16'sd0, 16'sd0, 32'hFFFF_FFF8, 16'sd0);
    send_item(KIND_COMPUTE, 16'sd1, 16'sd0, 32'h0000_0001, 16'sd0);
    send_item(KIND_COMPUTE, 16'sd2, 16'sd0, 32'h0000_0002, -16'sd1);
    drain();

    // crossed limits and a zero period
    s.low = 16'sd20;
    s.high = -16'sd20;
    s.period = 16'd0;
    load_setting(s);
    send_item(KIND_COMPUTE, 16'sd5, 16'sd9, 32'd7, 16'sd0);
    send_item(KIND_COMPUTE, 16'sd6, 16'sd9, 32'd7, 16'sd0);
    send_item(KIND_MANUAL, 16'sd0, 16'sd0, 32'd7, 16'sd0);
    send_item(KIND_AUTO, 16'sd4, 16'sd0, 32'd7, 16'sd0);
    send_item(KIND_COMPUTE, -16'sd30, 16'sd30, 32'd7, 16'sd0);
    drain();

    clock_ms = $urandom();
    for (int p = 0; p < RandPhases; p++) begin
      load_setting(pick_setting(p));
      target = 16'($urandom());
      repeat (PhaseItems) send_random();
      drain();
    end
    repeat (10) @(posedge clk);

    $display("Checked %0d result transactions, %0d of them fresh computations,",
             drives_checked, updates_seen);
    $display("across %0d register settings with random gaps and receiver hold-offs.",
             settings_loaded);
    if (fail_count == 0 && drives_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
